@@ hw/rtl/otb_pkg.sv @@
package otb_pkg;

  localparam int NUM_SLOTS = 64;
  localparam int IDX_W     = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  // scan counter also holds NUM_SLOTS itself
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

  localparam int FUNC_W    = 3;
  localparam int SLOT_W    = 6;
  localparam int TICKS_W   = 16;
  localparam int STATUS_W  = 2;

  localparam logic [FUNC_W-1:0] FUNC_CREATE = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_START  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_STOP   = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_TICK   = 3'd4;

  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_NOALLOC = 2'd2;

  typedef logic [NUM_SLOTS-1:0] slot_vec_t;

endpackage

@@ hw/rtl/otb_ram.sv @@
module otb_ram #(
  parameter int DEPTH  = 64,
  parameter int WIDTH  = 16,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/one_shot_timer_bank_core.sv @@
// channel   | handshake           | payload
// ----------+---------------------+----------------------------------
// command   | start / busy        | func, timer_id, seconds
// result    | result_valid strobe | status, slot_out, fired, last
//
// start, stop and delete keep busy low, and the result shows next cycle.
// create scans the allocation flags from slot zero, one slot a cycle, up to the lowest
// free slot. a tick walks the counter memory through its single read port, one slot
// a cycle.
// rst (synchronous) clears the allocation and armed flags; start writes a counter
// before use. results are one-cycle strobes that the receiver cannot hold off.
module one_shot_timer_bank_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [otb_pkg::FUNC_W-1:0]     func,
  input  logic [otb_pkg::SLOT_W-1:0]     timer_id,
  input  logic [otb_pkg::TICKS_W-1:0]    seconds,
  output logic                           result_valid,
  output logic [otb_pkg::STATUS_W-1:0]   status,
  output logic [otb_pkg::SLOT_W-1:0]     slot_out,
  output logic                           fired,
  output logic                           last
);

  typedef enum logic [1:0] {S_IDLE, S_CREATE, S_TICK} state_t;

  state_t                        state;
  otb_pkg::slot_vec_t            allocated_map;
  otb_pkg::slot_vec_t            armed_flags;
  logic [otb_pkg::CNT_W-1:0]     idx;
  logic                          pipe_vld;
  logic [otb_pkg::IDX_W-1:0]     pipe_idx;
  logic                          hold_vld;
  logic [otb_pkg::IDX_W-1:0]     hold_idx;

  logic                          accept;
  logic                          id_ok;
  logic [otb_pkg::IDX_W-1:0]     id_idx;
  logic                          scan_end;
  logic [otb_pkg::IDX_W-1:0]     scan_idx;
  logic                          proc_armed;
  logic [otb_pkg::TICKS_W-1:0]   rd_data;
  logic [otb_pkg::TICKS_W-1:0]   proc_dec;
  logic                          proc_fire;
  logic                          mem_we;
  logic [otb_pkg::IDX_W-1:0]     mem_waddr;
  logic [otb_pkg::TICKS_W-1:0]   mem_wdata;

  assign accept   = start && !busy;
  assign busy     = (state != S_IDLE);
  assign id_idx   = timer_id[otb_pkg::IDX_W-1:0];
  assign id_ok    = ({1'b0, timer_id} < (otb_pkg::SLOT_W + 1)'(otb_pkg::NUM_SLOTS))
                    && allocated_map[id_idx];
  assign scan_end = (idx == otb_pkg::CNT_W'(otb_pkg::NUM_SLOTS));
  assign scan_idx = idx[otb_pkg::IDX_W-1:0];

  // counter read-modify-write of the slot read last cycle
  assign proc_armed = pipe_vld && armed_flags[pipe_idx];
  assign proc_dec   = (rd_data != '0) ? rd_data - 1'b1 : '0;
  assign proc_fire  = proc_armed && (proc_dec == '0);

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = pipe_idx;
    mem_wdata = proc_dec;
    if (state == S_TICK) begin
      mem_we = proc_armed;
    end else if (accept && func == otb_pkg::FUNC_START && id_ok) begin
      mem_we    = 1'b1;
      mem_waddr = id_idx;
      mem_wdata = seconds;
    end
  end

  otb_ram #(
    .DEPTH (otb_pkg::NUM_SLOTS),
    .WIDTH (otb_pkg::TICKS_W)
  ) u_ticks (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (scan_idx),
    .rdata (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      allocated_map <= '0;
      armed_flags   <= '0;
      idx           <= '0;
      pipe_vld      <= 1'b0;
      hold_vld      <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            idx      <= '0;
            pipe_vld <= 1'b0;
            hold_vld <= 1'b0;
            fired    <= 1'b0;
            last     <= 1'b1;
            slot_out <= timer_id;
            unique case (func) inside
              otb_pkg::FUNC_CREATE: state <= S_CREATE;
              otb_pkg::FUNC_TICK:   state <= S_TICK;
              otb_pkg::FUNC_START, otb_pkg::FUNC_STOP, otb_pkg::FUNC_DELETE: begin
                result_valid <= 1'b1;
                if (!id_ok) begin
                  status <= otb_pkg::ST_NOALLOC;
                end else begin
                  status <= otb_pkg::ST_OK;
                  armed_flags[id_idx] <= (func == otb_pkg::FUNC_START);
                  if (func == otb_pkg::FUNC_DELETE) begin
                    allocated_map[id_idx] <= 1'b0;
                  end
                end
              end
              default: ;
            endcase
          end
        end
        S_CREATE: begin
          fired <= 1'b0;
          last  <= 1'b1;
          if (scan_end) begin
            result_valid <= 1'b1;
            status       <= otb_pkg::ST_FULL;
            slot_out     <= '0;
            state        <= S_IDLE;
          end else if (!allocated_map[scan_idx]) begin
            result_valid            <= 1'b1;
            status                  <= otb_pkg::ST_OK;
            slot_out                <= otb_pkg::SLOT_W'(scan_idx);
            allocated_map[scan_idx] <= 1'b1;
            armed_flags[scan_idx]   <= 1'b0;
            state                   <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_TICK: begin
          if (!scan_end) begin
            pipe_vld <= 1'b1;
            pipe_idx <= scan_idx;
            idx      <= idx + 1'b1;
          end else begin
            pipe_vld <= 1'b0;
          end
          // a fired slot waits in the hold stage until we know if it is the last
          if (proc_fire) begin
            armed_flags[pipe_idx]   <= 1'b0;
            allocated_map[pipe_idx] <= 1'b0;
            hold_vld                <= 1'b1;
            hold_idx                <= pipe_idx;
            if (hold_vld) begin
              result_valid <= 1'b1;
              status       <= otb_pkg::ST_OK;
              slot_out     <= otb_pkg::SLOT_W'(hold_idx);
              fired        <= 1'b1;
              last         <= 1'b0;
            end
          end
          if (scan_end && !pipe_vld) begin
            state    <= S_IDLE;
            hold_vld <= 1'b0;
            if (hold_vld) begin
              result_valid <= 1'b1;
              status       <= otb_pkg::ST_OK;
              slot_out     <= otb_pkg::SLOT_W'(hold_idx);
              fired        <= 1'b1;
              last         <= 1'b1;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_fired_ok: assert property (@(posedge clk) disable iff (rst)
    result_valid && fired |-> status == otb_pkg::ST_OK)
    else $error("fired result without ok status");

  a_fired_retired: assert property (@(posedge clk) disable iff (rst)
    result_valid && fired |->
      !armed_flags[slot_out[otb_pkg::IDX_W-1:0]] &&
      !allocated_map[slot_out[otb_pkg::IDX_W-1:0]])
    else $error("fired slot still armed or allocated");

  a_idle_drained: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !hold_vld && !pipe_vld)
    else $error("tick pipeline not drained when idle");

  a_armed_alloc: assert property (@(posedge clk) disable iff (rst)
    (armed_flags & ~allocated_map) == '0)
    else $error("armed slot is not allocated");
`endif

endmodule

@@ verif/tb_one_shot_timer_bank_core.sv @@
`timescale 1ns / 1ps

module tb_one_shot_timer_bank_core;

  localparam int LIMIT_CYCLES = 300000;
  localparam int SETTLE_CYCLES = 2 * otb_pkg::NUM_SLOTS + 8;
  localparam logic [otb_pkg::FUNC_W-1:0] FUNC_SPARE_FIRST = otb_pkg::FUNC_TICK + 3'd1;
  localparam logic [otb_pkg::FUNC_W-1:0] FUNC_SPARE_LAST = 3'd7;

  typedef struct packed {
    logic [otb_pkg::STATUS_W-1:0] status;
    logic [otb_pkg::SLOT_W-1:0] slot;
    logic fired;
    logic last;
  } timer_result_t;

  class timer_bank_scoreboard;
    bit slot_taken [otb_pkg::NUM_SLOTS];
    bit slot_armed [otb_pkg::NUM_SLOTS];
    bit [otb_pkg::TICKS_W-1:0] ticks_left [otb_pkg::NUM_SLOTS];
    timer_result_t due_results[$];
    int errors;

    function new();
      errors = 0;
    endfunction

    function void push(logic [otb_pkg::STATUS_W-1:0] st, int slot, bit fr, bit ls);
      timer_result_t r;
      r.status = st;
      r.slot = slot[otb_pkg::SLOT_W-1:0];
      r.fired = fr;
      r.last = ls;
      due_results.push_back(r);
    endfunction

    // advance the bank state by one accepted transaction
    function void note_command(logic [otb_pkg::FUNC_W-1:0] f,
                               logic [otb_pkg::SLOT_W-1:0] id,
                               logic [otb_pkg::TICKS_W-1:0] secs);
      int first_free;
      int n_fired;
      first_free = -1;
      n_fired = 0;
      case (f) inside
        otb_pkg::FUNC_CREATE: begin
          for (int i = 0; i < otb_pkg::NUM_SLOTS; i++)
            if (!slot_taken[i] && first_free < 0) first_free = i;
          if (first_free < 0) begin
            push(otb_pkg::ST_FULL, 0, 1'b0, 1'b1);
          end else begin
            slot_taken[first_free] = 1'b1;
            slot_armed[first_free] = 1'b0;
            push(otb_pkg::ST_OK, first_free, 1'b0, 1'b1);
          end
        end
        otb_pkg::FUNC_START, otb_pkg::FUNC_STOP, otb_pkg::FUNC_DELETE: begin
          if (int'(id) >= otb_pkg::NUM_SLOTS || !slot_taken[id]) begin
            push(otb_pkg::ST_NOALLOC, int'(id), 1'b0, 1'b1);
          end else begin
            if (f == otb_pkg::FUNC_START) begin
              ticks_left[id] = secs;
              slot_armed[id] = 1'b1;
            end else if (f == otb_pkg::FUNC_STOP) begin
              slot_armed[id] = 1'b0;
            end else begin
              slot_armed[id] = 1'b0;
              slot_taken[id] = 1'b0;
            end
            push(otb_pkg::ST_OK, int'(id), 1'b0, 1'b1);
          end
        end
        otb_pkg::FUNC_TICK: begin
          for (int i = 0; i < otb_pkg::NUM_SLOTS; i++) begin
            if (slot_armed[i]) begin
              if (ticks_left[i] != '0) ticks_left[i] = ticks_left[i] - 1'b1;
              if (ticks_left[i] == '0) begin
                slot_armed[i] = 1'b0;
                slot_taken[i] = 1'b0;
                push(otb_pkg::ST_OK, i, 1'b1, 1'b0);
                n_fired++;
              end
            end
          end
          if (n_fired > 0) due_results[due_results.size() - 1].last = 1'b1;
        end
        default: ;
      endcase
    endfunction

    function void check_result(logic [otb_pkg::STATUS_W-1:0] st,
                               logic [otb_pkg::SLOT_W-1:0] sl,
                               logic fr, logic ls);
      timer_result_t r;
      if (due_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result status=%0d slot=%0d fired=%0d last=%0d",
                 $time, st, sl, fr, ls);
      end else begin
        r = due_results.pop_front();
        if (r.status !== st || r.slot !== sl || r.fired !== fr || r.last !== ls) begin
          errors++;
          $display("%0t: mismatch expected status=%0d slot=%0d fired=%0d last=%0d",
                   $time, r.status, r.slot, r.fired, r.last);
          $display("%0t:          actual   status=%0d slot=%0d fired=%0d last=%0d",
                   $time, st, sl, fr, ls);
        end
      end
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction

    function bit bank_full();
      foreach (slot_taken[i])
        if (!slot_taken[i]) return 1'b0;
      return 1'b1;
    endfunction

    function int pick_taken();
      int taken[$];
      foreach (slot_taken[i])
        if (slot_taken[i]) taken.push_back(i);
      if (taken.size() == 0) return -1;
      return taken[$urandom_range(0, taken.size() - 1)];
    endfunction
  endclass

  logic clk;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [otb_pkg::FUNC_W-1:0] func = otb_pkg::FUNC_CREATE;
  logic [otb_pkg::SLOT_W-1:0] timer_id = '0;
  logic [otb_pkg::TICKS_W-1:0] seconds = '0;
  logic result_valid;
  logic [otb_pkg::STATUS_W-1:0] status;
  logic [otb_pkg::SLOT_W-1:0] slot_out;
  logic fired;
  logic last;

  timer_bank_scoreboard sb = new();
  bit pace_gaps = 1'b1;
  int cycle_count = 0;

  one_shot_timer_bank_core dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .func(func),
    .timer_id(timer_id),
    .seconds(seconds),
    .result_valid(result_valid),
    .status(status),
    .slot_out(slot_out),
    .fired(fired),
    .last(last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // results first, then the transaction accepted at the same edge
  always @(posedge clk) begin
    if (!rst) begin
      if (result_valid) sb.check_result(status, slot_out, fired, last);
      if (start && !busy) sb.note_command(func, timer_id, seconds);
    end
  end

  task automatic issue_command(input logic [otb_pkg::FUNC_W-1:0] f,
                               input logic [otb_pkg::SLOT_W-1:0] id,
                               input logic [otb_pkg::TICKS_W-1:0] secs);
    int gap;
    gap = pace_gaps ? $urandom_range(0, 3) : 0;
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    func <= f;
    timer_id <= id;
    seconds <= secs;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk);
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  task automatic random_command();
    int pick;
    int slot;
    logic [otb_pkg::SLOT_W-1:0] id;
    logic [otb_pkg::TICKS_W-1:0] secs;
    pick = $urandom_range(0, 99);
    slot = sb.pick_taken();
    if (slot >= 0 && $urandom_range(0, 3) != 0) id = slot[otb_pkg::SLOT_W-1:0];
    else id = otb_pkg::SLOT_W'($urandom_range(0, otb_pkg::NUM_SLOTS - 1));
    case ($urandom_range(0, 4)) inside
      [0:2]: secs = otb_pkg::TICKS_W'($urandom_range(0, 4));
      3: secs = otb_pkg::TICKS_W'($urandom_range(0, 20));
      default: secs = otb_pkg::TICKS_W'($urandom_range(0, 65535));
    endcase
    if (pick < 20) issue_command(otb_pkg::FUNC_CREATE, id, secs);
    else if (pick < 50) issue_command(otb_pkg::FUNC_START, id, secs);
    else if (pick < 60) issue_command(otb_pkg::FUNC_STOP, id, secs);
    else if (pick < 70) issue_command(otb_pkg::FUNC_DELETE, id, secs);
    else if (pick < 95) issue_command(otb_pkg::FUNC_TICK, id, secs);
    else issue_command(FUNC_SPARE_FIRST + otb_pkg::FUNC_W'($urandom_range(0, 2)), id, secs);
  endtask

  task automatic random_burst(input int count);
    for (int n = 0; n < count; n++) begin
      if (n % 10 == 0) pace_gaps = $urandom_range(0, 1);
      if ($urandom_range(0, 19) == 0) drain_results();
      random_command();
    end
  endtask

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    int guard;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty tick, unallocated slots, rearm, zero count, spare codes
    issue_command(otb_pkg::FUNC_TICK, 6'd0, 16'd0);
    issue_command(otb_pkg::FUNC_START, 6'd0, 16'd5);
    issue_command(otb_pkg::FUNC_STOP, 6'd63, 16'd0);
    issue_command(otb_pkg::FUNC_DELETE, 6'd42, 16'hFFFF);
    issue_command(otb_pkg::FUNC_CREATE, 6'd63, 16'd0);
    issue_command(otb_pkg::FUNC_CREATE, 6'd21, 16'hAAAA);
    issue_command(otb_pkg::FUNC_CREATE, 6'd0, 16'd0);
    issue_command(otb_pkg::FUNC_START, 6'd0, 16'd0);
    issue_command(otb_pkg::FUNC_START, 6'd1, 16'd2);
    issue_command(otb_pkg::FUNC_START, 6'd2, 16'hFFFF);
    issue_command(otb_pkg::FUNC_STOP, 6'd2, 16'd0);
    issue_command(otb_pkg::FUNC_STOP, 6'd2, 16'd0);
    issue_command(otb_pkg::FUNC_START, 6'd1, 16'd1);
    for (int k = 0; k <= int'(FUNC_SPARE_LAST - FUNC_SPARE_FIRST); k++)
      issue_command(FUNC_SPARE_FIRST + otb_pkg::FUNC_W'(k),
                    otb_pkg::SLOT_W'($urandom_range(0, 63)),
                    otb_pkg::TICKS_W'($urandom_range(0, 65535)));
    issue_command(otb_pkg::FUNC_TICK, 6'd0, 16'd0);
    issue_command(otb_pkg::FUNC_TICK, 6'd0, 16'd0);
    issue_command(otb_pkg::FUNC_CREATE, 6'd0, 16'd0);
    issue_command(otb_pkg::FUNC_DELETE, 6'd0, 16'd0);
    issue_command(otb_pkg::FUNC_DELETE, 6'd0, 16'd0);
    issue_command(otb_pkg::FUNC_START, 6'd2, 16'd3);
    issue_command(otb_pkg::FUNC_DELETE, 6'd2, 16'd0);
    issue_command(otb_pkg::FUNC_TICK, 6'd0, 16'd0);

    random_burst(15);
    drain_results();

    // fill the bank, then ask for more
    pace_gaps = 1'b0;
    guard = 0;
    while (!sb.bank_full() && guard < 80) begin
      issue_command(otb_pkg::FUNC_CREATE, otb_pkg::SLOT_W'($urandom_range(0, 63)), 16'd0);
      guard++;
    end
    issue_command(otb_pkg::FUNC_CREATE, 6'd0, 16'd0);
    issue_command(otb_pkg::FUNC_CREATE, 6'd63, 16'hFFFF);

    // arm every slot alike so the second tick retires the whole bank
    for (int s = 0; s < otb_pkg::NUM_SLOTS; s++) begin
      if (s == otb_pkg::NUM_SLOTS / 2) pace_gaps = 1'b1;
      issue_command(otb_pkg::FUNC_START, otb_pkg::SLOT_W'(s), 16'd2);
    end
    issue_command(otb_pkg::FUNC_TICK, 6'd0, 16'd0);
    issue_command(otb_pkg::FUNC_TICK, 6'd0, 16'd0);

    random_burst(20);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule
